>>> hdl/wmms_pkg.sv
// ----------------------------------------------------------------------------
// Windowed statistics package
// Shared widths, command and mode codes for the per-channel statistics core.
// ----------------------------------------------------------------------------
package wmms_pkg;

  localparam int unsigned NUM_CHANNELS = 6;
  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned OUT_BITS     = 24;
  localparam int unsigned ACC_BITS     = 32;
  localparam int unsigned COUNT_BITS   = 8;
  localparam int unsigned CMD_BITS     = 2;
  localparam int unsigned CH_BITS      = 3;
  localparam int unsigned MODE_BITS    = 2;
  localparam int unsigned CFG_BITS     = MODE_BITS * NUM_CHANNELS;
  localparam int unsigned CH_IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned BIT_CNT_BITS = $clog2(ACC_BITS);

  localparam logic [CFG_BITS-1:0]   CFG_RESET = CFG_BITS'(144);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_MEAN = 2'd0,
    MODE_MAX  = 2'd1,
    MODE_MIN  = 2'd2,
    MODE_HOLD = 2'd3
  } mode_e;

endpackage

>>> hdl/windowed_min_max_mean_stats_core.sv
// ----------------------------------------------------------------------------
// Windowed min/max/mean statistics core
// Per-channel accumulators updated by a bit-serial adder/comparator, with a
// bit-serial restoring divider for the mean. One word is worked on at a time.
// ----------------------------------------------------------------------------
// Sequence: an add word is accepted, shifted bit-serially through the
// accumulator (ST_ADD) and written back (ST_ADD_WB); a mean read of a
// non-empty channel runs the divider (ST_DIV), saturates (ST_SAT) and
// finishes (ST_FIN); any other read goes straight to ST_FIN; clear completes
// on acceptance. in_stall_o holds off new words until the core is idle. Reset
// clears all sample counts and loads the mode register with 144; accumulator
// contents are undefined until a window's first sample.
module windowed_min_max_mean_stats_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [wmms_pkg::CFG_BITS-1:0]       cfg_wr_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [wmms_pkg::CMD_BITS-1:0]       command_i,
  input  logic [wmms_pkg::CH_BITS-1:0]        channel_i,
  input  logic signed [wmms_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wmms_pkg::OUT_BITS-1:0] stat_value_o,
  output logic                                stat_valid_o,
  output logic                                count_full_o
);

  import wmms_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ADD    = 6'b000010,
    ST_ADD_WB = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_SAT    = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  localparam logic [BIT_CNT_BITS-1:0] BIT_LAST = BIT_CNT_BITS'(ACC_BITS - 1);
  localparam logic [ACC_BITS-1:0] POS_LIMIT = ACC_BITS'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam logic [ACC_BITS-1:0] NEG_LIMIT = ACC_BITS'(64'd1 << (OUT_BITS - 1));
  localparam logic [OUT_BITS-1:0] OUT_MAX_V = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] OUT_MIN_V = {1'b1, {(OUT_BITS-1){1'b0}}};

  state_e state_q, state_d;

  logic [CFG_BITS-1:0]   modes_q;
  logic [ACC_BITS-1:0]   acc_q   [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] count_q [NUM_CHANNELS];

  logic [ACC_BITS-1:0]     sh_acc_q;
  logic [ACC_BITS-1:0]     sh_smp_q;
  logic [BIT_CNT_BITS-1:0] bit_cnt_q;
  logic                    carry_q;
  logic                    lt_q;
  logic                    gt_q;
  logic                    first_q;
  mode_e                   mode_q;
  logic [CH_IDX_BITS-1:0]  ch_q;
  logic [COUNT_BITS-1:0]   rem_q;
  logic [COUNT_BITS-1:0]   divisor_q;
  logic                    neg_q;

  logic [OUT_BITS-1:0] res_value_q;
  logic                res_valid_q;
  logic                res_full_q;

  logic                out_valid_q;
  logic [OUT_BITS-1:0] out_value_q;
  logic                out_stat_valid_q;
  logic                out_full_q;

  // Decode of the incoming word.
  logic                   accept;
  logic                   ch_ok;
  logic [CH_IDX_BITS-1:0] ch_idx;
  mode_e                  mode_sel;
  logic [ACC_BITS-1:0]    acc_sel;
  logic [COUNT_BITS-1:0]  cnt_sel;
  logic [ACC_BITS-1:0]    acc_mag;
  logic [ACC_BITS-1:0]    smp_ext;

  // Serial datapath.
  logic                  a_b;
  logic                  s_b;
  logic                  sum_b;
  logic                  last_bit;
  logic [COUNT_BITS:0]   rem_ext;
  logic                  rem_ge;
  logic [COUNT_BITS:0]   rem_sub;
  logic [ACC_BITS-1:0]   quo_neg;
  logic [ACC_BITS-1:0]   wb_value;
  logic                  out_load;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    ch_ok    = (32'(channel_i) < NUM_CHANNELS);
    ch_idx   = CH_IDX_BITS'(channel_i);
    mode_sel = MODE_MEAN;
    acc_sel  = '0;
    cnt_sel  = '0;
    if (ch_ok) begin
      mode_sel = mode_e'(modes_q[MODE_BITS*ch_idx +: MODE_BITS]);
      acc_sel  = acc_q[ch_idx];
      cnt_sel  = count_q[ch_idx];
    end
    acc_mag = acc_sel[ACC_BITS-1] ? ('0 - acc_sel) : acc_sel;
    smp_ext = {{(ACC_BITS-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  end

  always_comb begin
    a_b      = sh_acc_q[0];
    s_b      = sh_smp_q[0];
    sum_b    = a_b ^ s_b ^ carry_q;
    last_bit = (bit_cnt_q == BIT_LAST);
    rem_ext  = {rem_q, sh_acc_q[ACC_BITS-1]};
    rem_ge   = (rem_ext >= {1'b0, divisor_q});
    rem_sub  = rem_ext - {1'b0, divisor_q};
    quo_neg  = '0 - sh_acc_q;
    out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    wb_value = sh_acc_q;
    if (first_q) begin
      wb_value = sh_smp_q;
    end else begin
      case (mode_q)
        MODE_MEAN: wb_value = sh_acc_q;
        MODE_MAX:  wb_value = lt_q ? sh_smp_q : sh_acc_q;
        MODE_MIN:  wb_value = gt_q ? sh_smp_q : sh_acc_q;
        default:   wb_value = sh_acc_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_ADD: begin
              if (ch_ok && (cnt_sel != COUNT_MAX)) begin
                state_d = ST_ADD;
              end
            end
            CMD_READ: begin
              if (ch_ok && (cnt_sel != '0) && (mode_sel == MODE_MEAN)) begin
                state_d = ST_DIV;
              end else begin
                state_d = ST_FIN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD:    state_d = last_bit ? ST_ADD_WB : ST_ADD;
      ST_ADD_WB: state_d = ST_IDLE;
      ST_DIV:    state_d = last_bit ? ST_SAT : ST_DIV;
      ST_SAT:    state_d = ST_FIN;
      ST_FIN:    state_d = out_load ? ST_IDLE : ST_FIN;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      modes_q   <= CFG_RESET;
      bit_cnt_q <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        modes_q <= cfg_wr_data_i;
      end
      if ((state_q == ST_ADD) || (state_q == ST_DIV)) begin
        bit_cnt_q <= bit_cnt_q + 1'b1;
      end else begin
        bit_cnt_q <= '0;
      end
      if (accept && (command_i == CMD_CLEAR)) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          count_q[i] <= '0;
        end
      end
      if (state_q == ST_ADD_WB) begin
        count_q[ch_q] <= count_q[ch_q] + 1'b1;
      end
    end
  end

  // Serial datapath and accumulator store; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      ch_q        <= ch_idx;
      mode_q      <= mode_sel;
      first_q     <= (cnt_sel == '0);
      carry_q     <= 1'b0;
      lt_q        <= 1'b0;
      gt_q        <= 1'b0;
      rem_q       <= '0;
      divisor_q   <= cnt_sel;
      neg_q       <= acc_sel[ACC_BITS-1];
      sh_smp_q    <= smp_ext;
      sh_acc_q    <= (mode_sel == MODE_MEAN && command_i == CMD_READ) ? acc_mag : acc_sel;
      res_valid_q <= ch_ok && (cnt_sel != '0);
      res_full_q  <= ch_ok && (cnt_sel == COUNT_MAX);
      res_value_q <= (ch_ok && (cnt_sel != '0)) ? acc_sel[OUT_BITS-1:0] : '0;
    end

    if (state_q == ST_ADD) begin
      carry_q  <= (a_b & s_b) | (a_b & carry_q) | (s_b & carry_q);
      // In mean mode the sum replaces the accumulator; otherwise it rotates
      // back to its original value after a full pass.
      sh_acc_q <= {(mode_q == MODE_MEAN) ? sum_b : a_b, sh_acc_q[ACC_BITS-1:1]};
      sh_smp_q <= {s_b, sh_smp_q[ACC_BITS-1:1]};
      // The most significant differing bit decides; the sign bit inverts it.
      if (a_b != s_b) begin
        lt_q <= last_bit ? a_b : s_b;
        gt_q <= last_bit ? s_b : a_b;
      end
    end

    if (state_q == ST_ADD_WB) begin
      acc_q[ch_q] <= wb_value;
    end

    if (state_q == ST_DIV) begin
      rem_q    <= rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_ext[COUNT_BITS-1:0];
      sh_acc_q <= {sh_acc_q[ACC_BITS-2:0], rem_ge};
    end

    if (state_q == ST_SAT) begin
      if (neg_q) begin
        res_value_q <= (sh_acc_q > NEG_LIMIT) ? OUT_MIN_V : quo_neg[OUT_BITS-1:0];
      end else begin
        res_value_q <= (sh_acc_q > POS_LIMIT) ? OUT_MAX_V : sh_acc_q[OUT_BITS-1:0];
      end
    end
  end

  // Output register: a finished word waits here while the core goes idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q      <= res_value_q;
      out_stat_valid_q <= res_valid_q;
      out_full_q       <= res_full_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign stat_value_o = out_value_q;
  assign stat_valid_o = out_stat_valid_q;
  assign count_full_o = out_full_q;

  a_out_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("output word appeared without a finished read");

  a_invalid_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !stat_valid_o) |-> (stat_value_o == '0 && !count_full_o))
    else $error("invalid statistic carries a non-zero value or full flag");

  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (divisor_q != '0))
    else $error("divider running with a zero count");

  a_cnt_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (bit_cnt_q == '0))
    else $error("bit counter not cleared when idle");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed statistics core testbench
// Drives add, read, clear and unused command words into the core under random
// sender gaps and receiver stalls. A predictor tracks every channel's
// accumulator and count and queues the statistic that each read should return.
// Each result word is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module testbench;
  import wmms_pkg::*;

  localparam int unsigned        DRAIN_CYCLES = 40;
  localparam int unsigned        LONG_HOLD    = 400;
  localparam int unsigned        STALL_LIMIT  = 4000;
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX  = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN  = 24'h800000;

  typedef struct {
    logic [OUT_BITS-1:0] value;
    logic                valid;
    logic                full;
  } stat_word_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_wr_en_i   = 1'b0;
  logic [CFG_BITS-1:0]    cfg_wr_data_i = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic [CMD_BITS-1:0]    command_i     = '0;
  logic [CH_BITS-1:0]     channel_i     = '0;
  logic [SAMPLE_BITS-1:0] sample_i      = '0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic [OUT_BITS-1:0]    stat_value_o;
  logic                   stat_valid_o;
  logic                   count_full_o;

  // Predictor state.
  logic [CFG_BITS-1:0]   channel_modes = CFG_RESET;
  logic signed [ACC_BITS-1:0] chan_acc [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] chan_count [NUM_CHANNELS];
  stat_word_t            pending_stats [$];

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  bit          start_long_hold = 1'b0;
  int unsigned hold_left       = 0;
  int unsigned idle_cycles     = 0;
  int unsigned errors          = 0;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;

  windowed_min_max_mean_stats_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .stat_value_o  (stat_value_o),
    .stat_valid_o  (stat_valid_o),
    .count_full_o  (count_full_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      chan_acc[i]   = '0;
      chan_count[i] = '0;
    end
  end

  // Applies one accepted word to the predicted channel state and queues the
  // statistic that a read must return.
  function automatic void update_channel_stats(cmd_e cmd, logic [CH_BITS-1:0] ch,
                                               logic [SAMPLE_BITS-1:0] smp);
    stat_word_t                 want;
    mode_e                      mode;
    logic signed [ACC_BITS-1:0] ext;
    longint                     mean;
    bit                         in_range;

    in_range = (ch < NUM_CHANNELS);
    mode     = in_range ? mode_e'(channel_modes[MODE_BITS*ch +: MODE_BITS]) : MODE_MEAN;
    ext      = {{(ACC_BITS-SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};
    case (cmd)
      CMD_ADD: begin
        if (in_range && chan_count[ch] != COUNT_MAX) begin
          if (chan_count[ch] == '0) begin
            chan_acc[ch] = ext;
          end else begin
            case (mode)
              MODE_MEAN: chan_acc[ch] = chan_acc[ch] + ext;
              MODE_MAX:  if (chan_acc[ch] < ext) chan_acc[ch] = ext;
              MODE_MIN:  if (chan_acc[ch] > ext) chan_acc[ch] = ext;
              default:   ;
            endcase
          end
          chan_count[ch] = chan_count[ch] + 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_CHANNELS; i++) chan_count[i] = '0;
      end
      CMD_READ: begin
        want.value = '0;
        want.valid = 1'b0;
        want.full  = 1'b0;
        if (in_range && chan_count[ch] != '0) begin
          want.valid = 1'b1;
          want.full  = (chan_count[ch] == COUNT_MAX);
          if (mode == MODE_MEAN) begin
            // Signed division of 64-bit integers truncates towards zero.
            mean = longint'(chan_acc[ch]) / longint'({1'b0, chan_count[ch]});
            if (mean > 64'sd8388607) mean = 64'sd8388607;
            if (mean < -64'sd8388608) mean = -64'sd8388608;
            want.value = mean[OUT_BITS-1:0];
          end else begin
            want.value = chan_acc[ch][OUT_BITS-1:0];
          end
        end
        pending_stats.push_back(want);
      end
      default: ;
    endcase
  endfunction

  // Offers one word, with random gaps in front, and returns at the edge where
  // it is taken.
  task automatic send_word(cmd_e cmd, logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    channel_i  <= ch;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
    update_channel_stats(cmd, ch, smp);
    words_sent++;
  endtask

  // Waits for every queued statistic, then lets an add still in the serial
  // datapath finish.
  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_channel_modes(logic [CFG_BITS-1:0] value);
    drain_pending();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    channel_modes = value;
    cfg_wr_en_i   <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    int near_zero;
    near_zero = int'($urandom_range(2000)) - 1000;
    case ($urandom_range(4))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return near_zero[SAMPLE_BITS-1:0];
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CH_BITS-1:0] random_channel();
    if ($urandom_range(9) == 0) return CH_BITS'($urandom_range(7, NUM_CHANNELS));
    return CH_BITS'($urandom_range(NUM_CHANNELS - 1));
  endfunction

  // Reset modes: channels 0, 1, 4 and 5 mean, channel 2 max, channel 3 min.
  task automatic test_reset_modes();
    send_word(CMD_READ, 3'd0, '0);
    send_word(CMD_ADD, 3'd0, SMP_MAX);
    send_word(CMD_ADD, 3'd0, SMP_MAX);
    send_word(CMD_READ, 3'd0, '0);
    send_word(CMD_ADD, 3'd1, SMP_MIN);
    send_word(CMD_ADD, 3'd1, SMP_MIN);
    send_word(CMD_READ, 3'd1, '0);
    // A mean of -5/2 must truncate towards zero.
    send_word(CMD_ADD, 3'd4, -24'sd7);
    send_word(CMD_ADD, 3'd4, 24'sd2);
    send_word(CMD_READ, 3'd4, '0);
    send_word(CMD_ADD, 3'd2, -24'sd5);
    send_word(CMD_ADD, 3'd2, 24'sd7);
    send_word(CMD_ADD, 3'd2, SMP_MIN);
    send_word(CMD_READ, 3'd2, '0);
    send_word(CMD_ADD, 3'd3, 24'sd3);
    send_word(CMD_ADD, 3'd3, SMP_MIN);
    send_word(CMD_ADD, 3'd3, SMP_MAX);
    send_word(CMD_READ, 3'd3, '0);
    send_word(CMD_ADD, 3'd6, 24'sd5);
    send_word(CMD_READ, 3'd6, '0);
    send_word(CMD_READ, 3'd7, '0);
    send_word(CMD_NONE, 3'd0, SMP_MAX);
    send_word(CMD_CLEAR, 3'd0, '0);
    send_word(CMD_READ, 3'd0, '0);
  endtask

  // Hold mode, and a mean window whose mode changes part way through.
  task automatic test_mode_register();
    write_channel_modes('1);
    send_word(CMD_ADD, 3'd0, 24'sd100);
    send_word(CMD_ADD, 3'd0, 24'sd200);
    send_word(CMD_ADD, 3'd0, -24'sd300);
    send_word(CMD_READ, 3'd0, '0);
    send_word(CMD_READ, 3'd5, '0);
    write_channel_modes('0);
    send_word(CMD_CLEAR, 3'd0, '0);
    repeat (3) send_word(CMD_ADD, 3'd1, SMP_MAX);
    // The sum no longer fits the output, so max mode shows its low bits.
    write_channel_modes({{(CFG_BITS-4){1'b0}}, MODE_MAX, MODE_MEAN});
    send_word(CMD_READ, 3'd1, '0);
    send_word(CMD_ADD, 3'd1, 24'sd5);
    write_channel_modes({{(CFG_BITS-4){1'b0}}, MODE_MIN, MODE_MEAN});
    send_word(CMD_ADD, 3'd1, -24'sd9);
    write_channel_modes('0);
    send_word(CMD_READ, 3'd1, '0);
  endtask

  task automatic test_count_saturation();
    send_word(CMD_CLEAR, 3'd0, '0);
    repeat (254) send_word(CMD_ADD, 3'd5, random_sample());
    send_word(CMD_READ, 3'd5, '0);
    send_word(CMD_ADD, 3'd5, SMP_MIN);
    send_word(CMD_READ, 3'd5, '0);
    repeat (5) send_word(CMD_ADD, 3'd5, SMP_MAX);
    send_word(CMD_READ, 3'd5, '0);
  endtask

  // The receiver holds off while reads keep coming, so the core backs up.
  task automatic test_backpressure();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    start_long_hold = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (i % 3 == 0) send_word(CMD_ADD, random_channel(), random_sample());
      else send_word(CMD_READ, random_channel(), '0);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned send_pct [4] = '{0, 79, 0, 15};
    int unsigned recv_pct [4] = '{0, 0, 79, 15};
    int unsigned pick;
    cmd_e        cmd;

    for (int phase = 0; phase < 4; phase++) begin
      write_channel_modes(CFG_BITS'($urandom));
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      for (int n = 0; n < 75; n++) begin
        pick = $urandom_range(99);
        if (pick < 55)      cmd = CMD_ADD;
        else if (pick < 90) cmd = CMD_READ;
        else if (pick < 96) cmd = CMD_CLEAR;
        else                cmd = CMD_NONE;
        send_word(cmd, random_channel(), random_sample());
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off counted here when asked.
  always @(posedge clk_i) begin
    if (start_long_hold) begin
      start_long_hold = 1'b0;
      hold_left       = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    stat_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        $error("result word with no read waiting: stat_value %0d", $signed(stat_value_o));
        errors++;
      end else begin
        want = pending_stats.pop_front();
        results_checked++;
        if (stat_value_o !== want.value) begin
          $error("stat_value: expected %0d, got %0d", $signed(want.value),
                 $signed(stat_value_o));
          errors++;
        end
        if (stat_valid_o !== want.valid) begin
          $error("stat_valid: expected %0b, got %0b", want.valid, stat_valid_o);
          errors++;
        end
        if (count_full_o !== want.full) begin
          $error("count_full: expected %0b, got %0b", want.full, count_full_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_modes();
    test_mode_register();
    test_count_saturation();
    test_backpressure();
    test_random_traffic();
    drain_pending();
    $display("Sent %0d words, checked %0d statistics, wrote the mode register %0d times.",
             words_sent, results_checked, cfg_writes);
    $display("Covered all modes, mode changes, count saturation, idle channels and stalls.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
